// File: sv/ssks_pkg.sv
// ----------------------------------------------------------------------------
// ssks_pkg: shared types and codes of the sorted k-smallest store
// Operation codes, status codes and the command word that travels from the
// front end to the sorted cell array.
// ----------------------------------------------------------------------------
package ssks_pkg;

  localparam int FieldWidth = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Decoded command: the operation, a flag for a query count below one,
  // and the raw operand.
  typedef struct packed {
    op_e                          op;
    logic                         nonpos;
    logic signed [FieldWidth-1:0] operand;
  } cmd_t;

endpackage

// File: sv/ssks_if.sv
// ----------------------------------------------------------------------------
// ssks_if: request and result channels of the sorted k-smallest store
// Valid/ready channels; a word moves at a clock edge with valid and ready high.
// ----------------------------------------------------------------------------
interface ssks_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] operand;

  modport source (output valid, output opcode, output operand, input ready);
  modport sink   (input valid, input opcode, input operand, output ready);
endinterface

interface ssks_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sorted_value;
  logic               is_last;
  logic               status;

  modport source (output valid, output sorted_value, output is_last, output status,
                  input ready);
  modport sink   (input valid, input sorted_value, input is_last, input status,
                  output ready);
endinterface

// File: sv/ssks_front.sv
// ----------------------------------------------------------------------------
// ssks_front: request decoder and command queue
// Accepts request words, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ssks_front import ssks_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssks_req_if.sink   req_i,
  output logic       cmd_valid_o,
  output cmd_t       cmd_o,
  input  logic       cmd_ready_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  cmd_t       dec;
  logic       push, pop;

  // A query count of zero or below is taken as one downstream.
  always_comb begin
    dec.op      = op_e'(req_i.opcode);
    dec.nonpos  = req_i.operand[31] | (req_i.operand == '0);
    dec.operand = req_i.operand;
  end

  assign req_i.ready = (fill_q != 2'd2);
  assign push        = req_i.valid & req_i.ready;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign pop         = cmd_valid_o & cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: sv/ssks_back.sv
// ----------------------------------------------------------------------------
// ssks_back: sorted cell array and result streamer
// Keeps the values in a row of cells in ascending order and streams the
// smallest ones by rotating the row.
// ----------------------------------------------------------------------------
module ssks_back import ssks_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_ready_o,
  ssks_rsp_if.source rsp_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (VALUE_WIDTH > FieldWidth) ? VALUE_WIDTH : FieldWidth;

  typedef enum logic {
    S_IDLE,
    S_STREAM
  } state_e;

  state_e                        state_q;
  logic [CW-1:0]                 count_q, k_q, idx_q, k_clamp;
  logic                          out_valid_q, out_last_q, out_status_q;
  logic signed [FieldWidth-1:0]  out_value_q;

  logic signed [VALUE_WIDTH-1:0] cell_q [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] cell_d [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] prv_val [CAPACITY];
  logic signed [VALUE_WIDTH-1:0] nxt_val [CAPACITY];
  logic [CAPACITY:0]             gtx;

  logic signed [EW-1:0]          in_ext, out_ext;
  logic signed [VALUE_WIDTH-1:0] ins_val;
  logic full, out_free, pop, do_insert, emit, step, done, load_word;

  assign in_ext  = EW'(cmd_i.operand);
  assign ins_val = in_ext[VALUE_WIDTH-1:0];
  assign out_ext = EW'(cell_q[0]);

  assign full      = (count_q == CW'(CAPACITY));
  assign out_free  = ~out_valid_q | rsp_o.ready;
  assign cmd_ready_o = (state_q == S_IDLE) &&
                       ((cmd_i.op == OP_INSERT) || (count_q != '0) || out_free);
  assign pop       = cmd_valid_i & cmd_ready_o;
  assign do_insert = pop && (cmd_i.op == OP_INSERT) && !full;

  // Query count clamped to the stored count; a count below one is one.
  always_comb begin
    if (cmd_i.nonpos) begin
      k_clamp = CW'(1);
    end else if ($unsigned(cmd_i.operand) > FieldWidth'(count_q)) begin
      k_clamp = count_q;
    end else begin
      k_clamp = cmd_i.operand[CW-1:0];
    end
  end

  assign emit = (idx_q < k_q);
  assign step = (state_q == S_STREAM) && (!emit || out_free);
  assign done = (idx_q == count_q - CW'(1));

  // A new word enters the output register either for a query on an empty
  // store or for each emitting step of a stream.
  assign load_word = (state_q == S_IDLE) ?
                     (pop && (cmd_i.op == OP_QUERY) && (count_q == '0)) :
                     (step && emit);

  // Each cell sees only its two neighbors, the head of the row and the new value.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_nbr
    if (g == 0) begin : g_head
      assign prv_val[g] = ins_val;
    end else begin : g_body
      assign prv_val[g] = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign nxt_val[g] = cell_q[0];
    end else begin : g_mid
      assign nxt_val[g] = (CW'(g + 1) == count_q) ? cell_q[0] : cell_q[g+1];
    end
  end

  // Insert: cells above the new value shift up by one, the value lands
  // after any equal entries. Stream: the filled part of the row rotates.
  always_comb begin
    gtx[0] = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      gtx[i+1] = (CW'(i) < count_q) && (cell_q[i] > ins_val);
    end
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
      if (do_insert) begin
        if (gtx[i]) begin
          cell_d[i] = prv_val[i];
        end else if (gtx[i+1] || (CW'(i) == count_q)) begin
          cell_d[i] = ins_val;
        end
      end else if (step) begin
        cell_d[i] = nxt_val[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      k_q          <= '0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_last_q   <= 1'b0;
      out_status_q <= STATUS_OK;
    end else begin
      if (load_word) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (pop) begin
            if (cmd_i.op == OP_INSERT) begin
              if (!full) count_q <= count_q + CW'(1);
            end else if (count_q == '0) begin
              out_value_q  <= '0;
              out_last_q   <= 1'b1;
              out_status_q <= STATUS_EMPTY;
            end else begin
              k_q     <= k_clamp;
              idx_q   <= '0;
              state_q <= S_STREAM;
            end
          end
        end
        S_STREAM: begin
          if (step) begin
            if (emit) begin
              out_value_q  <= out_ext[FieldWidth-1:0];
              out_last_q   <= (idx_q == k_q - CW'(1));
              out_status_q <= STATUS_OK;
            end
            if (done) begin
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + CW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.sorted_value = out_value_q;
  assign rsp_o.is_last      = out_last_q;
  assign rsp_o.status       = out_status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("stored count above capacity");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (cmd_i.op == OP_INSERT) && full) |=> (count_q == CW'(CAPACITY)))
    else $error("insert into a full store changed the count");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == $past(count_q) + CW'(1)))
    else $error("insert did not grow the count by one");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == STATUS_EMPTY)) |-> out_last_q)
    else $error("empty-store word not marked last");

  a_stream_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STREAM) |-> ((count_q != '0) && (idx_q < count_q) && (k_q <= count_q)
                               && (k_q != '0)))
    else $error("stream index or count out of range");
`endif

endmodule

// File: sv/sorted_store_k_smallest_core.sv
// Query words pass the stream state and output register; an empty-store word only the register.
// Throughput: one insert per cycle while no query streams; a query holds the cell row while the
// row rotates once around to return to its order, and emits one word per cycle while each word
// is taken.
// Reset clears the stored count and the command queue at once; the cells hold no reset value and
// need no clearing pass, so the block takes words as soon as reset is released.
// ----------------------------------------------------------------------------
// sorted_store_k_smallest_core: top level of the sorted k-smallest store
// A front end decodes request words into a short queue; a back end keeps the
// values sorted in a row of cells and streams the smallest ones on request.
// ----------------------------------------------------------------------------
module sorted_store_k_smallest_core import ssks_pkg::*; #(
  parameter int CAPACITY    = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssks_req_if.sink   req_i,
  ssks_rsp_if.source rsp_o
);

  // The front end takes a request word whenever its two-entry queue has room,
  // so it keeps accepting while the back end is busy streaming a query.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  ssks_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  // The back end places each inserted value in order by a parallel update of all cells: every
  // cell compares itself with the new value and either keeps its entry, takes
  // its lower neighbor's entry or takes the new value. A query rotates the
  // filled cells toward the head; the head cell feeds the output register for
  // the first k steps, and the remaining steps restore the original order.
  // An insert into a full store is dropped. The output register lets the back
  // end go on with inserts and non-emitting steps while a finished word waits to be taken.
  ssks_back #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .rsp_o       (rsp_o)
  );

endmodule
